// ===== hdl/tcb_pkg.sv =====
// ---------------------------------------------------------------------------
// tcb_pkg
// types, codes and blend helpers shared by the cell blitter
// ---------------------------------------------------------------------------
`default_nettype none
package tcb_pkg;
   localparam logic [7:0] SPACE_CODE  = 8'h20;
   localparam logic [7:0] CORNER_CODE = 8'h2b;
   localparam logic [7:0] HORIZ_CODE  = 8'h2d;
   localparam logic [7:0] VERT_CODE   = 8'h7c;

   typedef enum logic [1:0] {
      OP_CELL = 2'd0,
      OP_FILL = 2'd1,
      OP_BOX  = 2'd2,
      OP_READ = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_CHAR_OP = 3'd0,
      REG_FG_OP   = 3'd1,
      REG_BG_OP   = 3'd2,
      REG_WR_CHAR = 3'd3,
      REG_WR_FG   = 3'd4,
      REG_WR_BG   = 3'd5
   } reg_index_type;

   localparam logic [1:0] BLEND_ADD = 2'd1;
   localparam logic [1:0] BLEND_MUL = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_READ,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       char_op;
      logic [1:0] fg_op;
      logic [1:0] bg_op;
      logic       wr_char;
      logic       wr_fg;
      logic       wr_bg;
   } cfg_type;

   // multiply by reciprocal of 255, one correction step
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] q;
      logic [16:0] r;
      begin
         q = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
         r = {8'd0, q[16:8]};
         div255 = r[7:0];
      end
   endfunction
endpackage
`default_nettype wire

// ===== hdl/tcb_blend.sv =====
// ---------------------------------------------------------------------------
// tcb_blend
// blends one source cell with the stored cell
// ---------------------------------------------------------------------------
`default_nettype none
module tcb_blend
   import tcb_pkg::*;
(
   input  wire cfg_type     cfg,
   input  wire logic [7:0]  src_glyph,
   input  wire logic [31:0] src_fore,
   input  wire logic [31:0] src_back,
   input  wire logic [7:0]  dst_glyph,
   input  wire logic [31:0] dst_fore,
   input  wire logic [31:0] dst_back,
   output logic      [7:0]  new_glyph,
   output logic      [31:0] new_fore,
   output logic      [31:0] new_back
);
   function automatic logic [31:0] mix(input logic [31:0] s, input logic [31:0] d,
                                       input logic [1:0] op);
      logic [31:0] res;
      logic [8:0]  sum;
      logic [15:0] prod;
      begin
         res = {s[31:24], 24'd0};
         for (int k = 0; k < 3; k++) begin
            sum  = {1'b0, s[k*8 +: 8]} + {1'b0, d[k*8 +: 8]};
            prod = s[k*8 +: 8] * d[k*8 +: 8];
            if (op == BLEND_ADD) res[k*8 +: 8] = sum[8] ? 8'hff : sum[7:0];
            else                 res[k*8 +: 8] = div255(prod);
         end
         if (op != BLEND_ADD && op != BLEND_MUL) res = s;
         mix = res;
      end
   endfunction

   always_comb begin
      new_glyph = (cfg.char_op && dst_glyph != SPACE_CODE) ? dst_glyph : src_glyph;
      new_fore  = mix(src_fore, dst_fore, cfg.fg_op);
      new_back  = mix(src_back, dst_back, cfg.bg_op);
   end
endmodule
`default_nettype wire

// ===== hdl/text_cell_blitter_with_blend_top.sv =====
// ---------------------------------------------------------------------------
// text_cell_blitter_with_blend_top
// character cell framebuffer blitter with blend operations
// ---------------------------------------------------------------------------
// one command item enters on req_ and gives one result item on rsp_.
// config registers are written on csr_ while the block is idle; the
// user must keep to this, as the block itself does not enforce it.
// after reset a clearing pass sweeps the store before the first item
// is taken; req_ready is low meanwhile. the sequencer visits each
// cell in three steps (address, memory read, then blend and write
// back); out of bounds and transparent cells are skipped in the address
// step, without a memory read or write back.
// the result waits in an output register; a stalled receiver holds the
// block in its done step and no new item is taken until it is collected.
// ---------------------------------------------------------------------------
`default_nettype none
module text_cell_blitter_with_blend_top
   import tcb_pkg::*;
#(
   parameter int BUF_WIDTH  = 128,
   parameter int BUF_HEIGHT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [15:0] req_x_pos,
   input  wire logic [15:0] req_y_pos,
   input  wire logic [7:0]  req_rect_width,
   input  wire logic [7:0]  req_rect_height,
   input  wire logic [7:0]  req_glyph,
   input  wire logic [31:0] req_fore_color,
   input  wire logic [31:0] req_back_color,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_read_glyph,
   output logic      [31:0] rsp_read_fore,
   output logic      [31:0] rsp_read_back,
   output logic      [15:0] rsp_cells_written,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int CELLS = BUF_WIDTH * BUF_HEIGHT;
   localparam int AW    = $clog2(CELLS);

   state_type state_ff, state_in;
   cfg_type   cfg_ff;

   logic [AW-1:0] clr_ff;
   logic [1:0]    op_ff;
   logic [17:0]   x0_ff, y0_ff;
   logic [7:0]    w_ff, h_ff, i_ff, j_ff;
   logic [7:0]    g_ff;
   logic [31:0]   fg_ff, bg_ff;
   logic [15:0]   cnt_ff;
   logic [AW-1:0] addr_ff;
   logic [7:0]    rd_g_ff;
   logic [31:0]   rd_f_ff, rd_b_ff;
   logic          rdok_ff;

   logic [7:0]  glyph_mem [CELLS];
   logic [31:0] fore_mem  [CELLS];
   logic [31:0] back_mem  [CELLS];

   // cell position and visit controls
   logic [17:0] cx, cy;
   logic        inb, last, visit;
   logic [7:0]  cg;
   logic [AW-1:0] caddr;
   logic [35:0] prod_y;
   logic [7:0]  ni, nj;

   always_comb begin
      cx = x0_ff + {10'd0, i_ff};
      cy = y0_ff + {10'd0, j_ff};
      inb = !cx[17] && !cy[17] && (cx < 18'(BUF_WIDTH)) && (cy < 18'(BUF_HEIGHT));
      prod_y = cy * 18'(BUF_WIDTH);
      caddr = AW'(prod_y + {18'd0, cx});
      ni = i_ff;
      nj = j_ff;
      last = 1'b1;
      visit = 1'b1;
      cg = g_ff;
      unique case (opcode_type'(op_ff))
         OP_FILL: begin
            visit = (w_ff != 8'd0) && (h_ff != 8'd0);
            last = !visit || (i_ff == w_ff - 8'd1 && j_ff == h_ff - 8'd1);
            if (i_ff == w_ff - 8'd1) begin
               ni = 8'd0;
               nj = j_ff + 8'd1;
            end else begin
               ni = i_ff + 8'd1;
            end
         end
         OP_BOX: begin
            visit = (w_ff != 8'd0) && (h_ff != 8'd0);
            last = !visit || (i_ff == w_ff - 8'd1 && j_ff == h_ff - 8'd1);
            if ((i_ff == 8'd0 || i_ff == w_ff - 8'd1) && (j_ff == 8'd0 || j_ff == h_ff - 8'd1))
               cg = CORNER_CODE;
            else if (j_ff == 8'd0 || j_ff == h_ff - 8'd1)
               cg = HORIZ_CODE;
            else
               cg = VERT_CODE;
            if (i_ff == w_ff - 8'd1) begin
               ni = 8'd0;
               nj = j_ff + 8'd1;
            end else if (j_ff == 8'd0 || j_ff == h_ff - 8'd1 || i_ff != 8'd0) begin
               ni = i_ff + 8'd1;
            end else begin
               ni = w_ff - 8'd1;
            end
         end
         default: ;
      endcase
      if (cg == 8'd0 || !inb) visit = 1'b0;
   end

   logic [7:0]  nb_g;
   logic [31:0] nb_f, nb_b;

   tcb_blend u_blend (
      .cfg(cfg_ff), .src_glyph(cg), .src_fore(fg_ff), .src_back(bg_ff),
      .dst_glyph(rd_g_ff), .dst_fore(rd_f_ff), .dst_back(rd_b_ff),
      .new_glyph(nb_g), .new_fore(nb_f), .new_back(nb_b)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(CELLS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_ISSUE;
         ST_ISSUE: begin
            if (opcode_type'(op_ff) == OP_READ) state_in = ST_READ;
            else if (visit) state_in = ST_READ;
            else if (last) state_in = ST_DONE;
         end
         ST_READ:  state_in = (opcode_type'(op_ff) == OP_READ) ? ST_DONE : ST_WRITE;
         ST_WRITE: state_in = last ? ST_DONE : ST_ISSUE;
         ST_DONE:  if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      csr_ready = 1'b1;
      rsp_cells_written = cnt_ff;
      rsp_read_glyph = 8'd0;
      rsp_read_fore  = 32'd0;
      rsp_read_back  = 32'd0;
      if (opcode_type'(op_ff) == OP_READ && rdok_ff) begin
         rsp_read_glyph = rd_g_ff;
         rsp_read_fore  = rd_f_ff;
         rsp_read_back  = rd_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         cfg_ff   <= '{char_op: 1'b0, fg_op: 2'd0, bg_op: 2'd0,
                       wr_char: 1'b1, wr_fg: 1'b1, wr_bg: 1'b1};
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (csr_valid) begin
            unique case (csr_index)
               REG_CHAR_OP: cfg_ff.char_op <= csr_data[0];
               REG_FG_OP:   cfg_ff.fg_op   <= csr_data[1:0];
               REG_BG_OP:   cfg_ff.bg_op   <= csr_data[1:0];
               REG_WR_CHAR: cfg_ff.wr_char <= csr_data[0];
               REG_WR_FG:   cfg_ff.wr_fg   <= csr_data[0];
               REG_WR_BG:   cfg_ff.wr_bg   <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff  <= req_opcode;
         x0_ff  <= {{2{req_x_pos[15]}}, req_x_pos};
         y0_ff  <= {{2{req_y_pos[15]}}, req_y_pos};
         w_ff   <= req_rect_width;
         h_ff   <= req_rect_height;
         g_ff   <= req_glyph;
         fg_ff  <= req_fore_color;
         bg_ff  <= req_back_color;
         i_ff   <= 8'd0;
         j_ff   <= 8'd0;
         cnt_ff <= 16'd0;
      end
      if (state_ff == ST_ISSUE) begin
         addr_ff <= caddr;
         rdok_ff <= inb;
         if (!visit && !last && opcode_type'(op_ff) != OP_READ) begin
            i_ff <= ni;
            j_ff <= nj;
         end
      end
      if (state_ff == ST_WRITE) begin
         cnt_ff <= cnt_ff + 16'd1;
         i_ff <= ni;
         j_ff <= nj;
      end
   end

   // memory: clear sweep, read port, write back
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         glyph_mem[clr_ff] <= SPACE_CODE;
         fore_mem[clr_ff]  <= 32'd0;
         back_mem[clr_ff]  <= 32'd0;
      end else if (state_ff == ST_WRITE) begin
         if (cfg_ff.wr_char) glyph_mem[addr_ff] <= nb_g;
         if (cfg_ff.wr_fg)   fore_mem[addr_ff]  <= nb_f;
         if (cfg_ff.wr_bg)   back_mem[addr_ff]  <= nb_b;
      end
      if (state_ff == ST_READ) begin
         rd_g_ff <= glyph_mem[addr_ff];
         rd_f_ff <= fore_mem[addr_ff];
         rd_b_ff <= back_mem[addr_ff];
      end
   end
endmodule
`default_nettype wire

// ===== tb/blit_checker.sv =====
// ----------------------------------------------------------------------------
// blit_checker
// watches the command, result and register channels of the cell blitter,
// keeps its own copy of the cell store and compares every result item
// ----------------------------------------------------------------------------
`default_nettype none
module blit_checker
   import tcb_pkg::*;
#(
   parameter int BUF_WIDTH  = 128,
   parameter int BUF_HEIGHT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [15:0] req_x_pos,
   input  wire logic [15:0] req_y_pos,
   input  wire logic [7:0]  req_rect_width,
   input  wire logic [7:0]  req_rect_height,
   input  wire logic [7:0]  req_glyph,
   input  wire logic [31:0] req_fore_color,
   input  wire logic [31:0] req_back_color,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [7:0]  rsp_read_glyph,
   input  wire logic [31:0] rsp_read_fore,
   input  wire logic [31:0] rsp_read_back,
   input  wire logic [15:0] rsp_cells_written,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]  glyph;
      logic [31:0] fore;
      logic [31:0] back;
      logic [15:0] count;
   } cell_result_type;

   localparam int CELLS = BUF_WIDTH * BUF_HEIGHT;

   logic [7:0]  glyph_mem [CELLS];
   logic [31:0] fore_mem [CELLS];
   logic [31:0] back_mem [CELLS];
   cfg_type     cfg;
   cell_result_type result_queue [$];

   function automatic logic [31:0] blend_colour(input logic [31:0] src, input logic [31:0] dst,
                                                input logic [1:0] op);
      logic [31:0] res;
      int          s;
      int          d;
      int          ch;
      if (op != BLEND_ADD && op != BLEND_MUL) return src;
      res = {src[31:24], 24'd0};
      for (int k = 0; k < 3; k++) begin
         s = src[8*k +: 8];
         d = dst[8*k +: 8];
         if (op == BLEND_ADD) ch = (s + d > 255) ? 255 : s + d;
         else ch = (s * d) / 255;
         res[8*k +: 8] = ch[7:0];
      end
      return res;
   endfunction

   function automatic int paint_cell(input int x, input int y, input logic [7:0] g,
                                     input logic [31:0] fg, input logic [31:0] bg);
      int idx;
      if (g == 8'd0) return 0;
      if (x < 0 || y < 0 || x >= BUF_WIDTH || y >= BUF_HEIGHT) return 0;
      idx = y * BUF_WIDTH + x;
      if (cfg.wr_char)
         glyph_mem[idx] = (cfg.char_op && glyph_mem[idx] != SPACE_CODE) ? glyph_mem[idx] : g;
      if (cfg.wr_fg) fore_mem[idx] = blend_colour(fg, fore_mem[idx], cfg.fg_op);
      if (cfg.wr_bg) back_mem[idx] = blend_colour(bg, back_mem[idx], cfg.bg_op);
      return 1;
   endfunction

   function automatic cell_result_type run_command();
      cell_result_type r;
      int x0;
      int y0;
      int w;
      int h;
      int x1;
      int y1;
      int n;
      r  = '0;
      n  = 0;
      x0 = $signed(req_x_pos);
      y0 = $signed(req_y_pos);
      w  = req_rect_width;
      h  = req_rect_height;
      x1 = x0 + w - 1;
      y1 = y0 + h - 1;
      case (opcode_type'(req_opcode))
         OP_CELL: n = paint_cell(x0, y0, req_glyph, req_fore_color, req_back_color);
         OP_FILL: begin
            for (int j = 0; j < h; j++)
               for (int i = 0; i < w; i++)
                  n += paint_cell(x0 + i, y0 + j, req_glyph, req_fore_color, req_back_color);
         end
         OP_BOX: begin
            if (w > 0 && h > 0) begin
               n += paint_cell(x0, y0, CORNER_CODE, req_fore_color, req_back_color);
               if (w > 1) n += paint_cell(x1, y0, CORNER_CODE, req_fore_color, req_back_color);
               if (h > 1) n += paint_cell(x0, y1, CORNER_CODE, req_fore_color, req_back_color);
               if (w > 1 && h > 1)
                  n += paint_cell(x1, y1, CORNER_CODE, req_fore_color, req_back_color);
               for (int i = x0 + 1; i < x1; i++) begin
                  n += paint_cell(i, y0, HORIZ_CODE, req_fore_color, req_back_color);
                  if (h > 1) n += paint_cell(i, y1, HORIZ_CODE, req_fore_color, req_back_color);
               end
               for (int j = y0 + 1; j < y1; j++) begin
                  n += paint_cell(x0, j, VERT_CODE, req_fore_color, req_back_color);
                  if (w > 1) n += paint_cell(x1, j, VERT_CODE, req_fore_color, req_back_color);
               end
            end
         end
         default: begin
            if (x0 >= 0 && y0 >= 0 && x0 < BUF_WIDTH && y0 < BUF_HEIGHT) begin
               r.glyph = glyph_mem[y0 * BUF_WIDTH + x0];
               r.fore  = fore_mem[y0 * BUF_WIDTH + x0];
               r.back  = back_mem[y0 * BUF_WIDTH + x0];
            end
         end
      endcase
      r.count = n[15:0];
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      cell_result_type want;
      if (reset) begin
         for (int k = 0; k < CELLS; k++) begin
            glyph_mem[k] = SPACE_CODE;
            fore_mem[k]  = '0;
            back_mem[k]  = '0;
         end
         cfg = '{char_op: 1'b0, fg_op: 2'd0, bg_op: 2'd0, wr_char: 1'b1, wr_fg: 1'b1,
                 wr_bg: 1'b1};
         result_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CHAR_OP: cfg.char_op = csr_data[0];
               REG_FG_OP:   cfg.fg_op   = csr_data[1:0];
               REG_BG_OP:   cfg.bg_op   = csr_data[1:0];
               REG_WR_CHAR: cfg.wr_char = csr_data[0];
               REG_WR_FG:   cfg.wr_fg   = csr_data[0];
               REG_WR_BG:   cfg.wr_bg   = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) result_queue = {result_queue, run_command()};
         if (rsp_valid && rsp_ready) begin
            if (result_queue.size() == 0) begin
               $display("unexpected result item at %0t", $realtime);
               fail_count++;
            end else begin
               want = result_queue.pop_front();
               if (rsp_read_glyph !== want.glyph) report("read_glyph", rsp_read_glyph, want.glyph);
               if (rsp_read_fore !== want.fore) report("read_fore", rsp_read_fore, want.fore);
               if (rsp_read_back !== want.back) report("read_back", rsp_read_back, want.back);
               if (rsp_cells_written !== want.count)
                  report("cells_written", rsp_cells_written, want.count);
            end
         end
      end
      pending <= result_queue.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the character cell blitter: directed commands,
// then phases of random commands under several blend settings, with bursty
// sending and a stalling receiver; checking is done by blit_checker
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   import tcb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT = 4000000;
   localparam logic [2:0]  REG_SPARE_A = 3'd6;
   localparam logic [2:0]  REG_SPARE_B = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [15:0] req_x_pos;
   logic [15:0] req_y_pos;
   logic [7:0]  req_rect_width;
   logic [7:0]  req_rect_height;
   logic [7:0]  req_glyph;
   logic [31:0] req_fore_color;
   logic [31:0] req_back_color;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_read_glyph;
   logic [31:0] rsp_read_fore;
   logic [31:0] rsp_read_back;
   logic [15:0] rsp_cells_written;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   int          fail_count;
   int          pending;
   int          cycle_count;
   int          stall_mode;
   int          big_left;

   text_cell_blitter_with_blend_top u_dut (.*);
   blit_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 0);
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= (cycle_count % 16 < 10);
      endcase
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic send_item(input opcode_type op, input int x, input int y, input int w,
                            input int h, input logic [7:0] g, input logic [31:0] fg,
                            input logic [31:0] bg);
      req_opcode      <= op;
      req_x_pos       <= x[15:0];
      req_y_pos       <= y[15:0];
      req_rect_width  <= w[7:0];
      req_rect_height <= h[7:0];
      req_glyph       <= g;
      req_fore_color  <= fg;
      req_back_color  <= bg;
      req_valid       <= 1'b1;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic hold_off(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      hold_off(1);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // valid stays high across back-to-back writes; the caller lowers it
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
   endtask

   function automatic int rand_coord(input int span);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 88) return $urandom_range(0, span + 12) - 6;
      if (pick < 96) return $signed(16'($urandom()));
      return pick[0] ? -32768 : 32767;
   endfunction

   task automatic random_item();
      int          pick;
      int          w;
      int          h;
      logic [7:0]  g;
      logic [31:0] fg;
      logic [31:0] bg;
      pick = $urandom_range(0, 99);
      g    = (pick % 10 == 0) ? 8'd0 : (pick % 10 == 1) ? SPACE_CODE : 8'($urandom());
      fg   = (pick % 7 == 0) ? 32'hffffffff : $urandom();
      bg   = (pick % 11 == 0) ? 32'd0 : $urandom();
      w    = $urandom_range(0, 10);
      h    = $urandom_range(0, 8);
      if (big_left > 0 && $urandom_range(0, 199) == 0) begin
         big_left--;
         w = $urandom_range(128, 255);
         h = $urandom_range(64, 255);
      end
      send_item(opcode_type'($urandom_range(0, 3)), rand_coord(128), rand_coord(64), w, h, g,
                fg, bg);
      if ($urandom_range(0, 2) == 0) send_item(OP_READ, rand_coord(128), rand_coord(64), 0, 0,
                                               8'($urandom()), $urandom(), $urandom());
   endtask

   initial begin
      int left;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = OP_CELL;
      req_x_pos   = '0;
      req_y_pos   = '0;
      req_rect_width  = '0;
      req_rect_height = '0;
      req_glyph       = '0;
      req_fore_color  = '0;
      req_back_color  = '0;
      csr_valid   = 1'b0;
      csr_index   = REG_CHAR_OP;
      csr_data    = '0;
      rsp_ready   = 1'b0;
      cycle_count = 0;
      stall_mode  = 0;
      big_left    = 4;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed commands under reset settings
      send_item(OP_READ, 0, 0, 0, 0, 8'h00, 32'h0, 32'h0);
      send_item(OP_CELL, 0, 0, 0, 0, 8'hff, 32'hffffffff, 32'hffffffff);
      send_item(OP_CELL, 127, 63, 0, 0, 8'h41, 32'h80402010, 32'h01020304);
      send_item(OP_CELL, -1, 5, 0, 0, 8'h41, 32'h1, 32'h2);
      send_item(OP_CELL, 128, 64, 0, 0, 8'h41, 32'h1, 32'h2);
      send_item(OP_CELL, 3, 3, 0, 0, 8'h00, 32'h1, 32'h2);
      send_item(OP_FILL, 10, 10, 0, 5, 8'h42, 32'h5, 32'h6);
      send_item(OP_FILL, 10, 10, 5, 0, 8'h42, 32'h5, 32'h6);
      send_item(OP_FILL, 4, 4, 6, 3, 8'h43, 32'h11223344, 32'h55667788);
      send_item(OP_FILL, -32768, -32768, 255, 255, 8'h44, 32'h9, 32'h9);
      send_item(OP_BOX, 20, 20, 1, 1, 8'h00, 32'haaaaaaaa, 32'h55555555);
      send_item(OP_BOX, 30, 20, 1, 6, 8'h00, 32'h1, 32'h2);
      send_item(OP_BOX, 40, 20, 7, 1, 8'h00, 32'h3, 32'h4);
      send_item(OP_BOX, 120, 58, 12, 9, 8'h00, 32'h5, 32'h6);
      send_item(OP_BOX, 50, 30, 0, 4, 8'h00, 32'h5, 32'h6);
      send_item(OP_READ, 20, 20, 0, 0, 8'h00, 32'h0, 32'h0);
      send_item(OP_READ, 127, 63, 0, 0, 8'h00, 32'h0, 32'h0);
      send_item(OP_READ, 121, 58, 0, 0, 8'h00, 32'h0, 32'h0);
      send_item(OP_READ, 5, 5, 0, 0, 8'h00, 32'h0, 32'h0);
      send_item(OP_READ, 32767, -1, 0, 0, 8'h00, 32'h0, 32'h0);
      send_item(OP_READ, 0, 64, 0, 0, 8'h00, 32'h0, 32'h0);

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            0: ;
            1: begin
               write_reg(REG_CHAR_OP, 32'd0);
               write_reg(REG_FG_OP, 32'd3);
               write_reg(REG_BG_OP, 32'd3);
               write_reg(REG_WR_CHAR, 32'd0);
               write_reg(REG_WR_FG, 32'd0);
               write_reg(REG_WR_BG, 32'd0);
               write_reg(REG_SPARE_A, 32'hffffffff);
            end
            2: begin
               write_reg(REG_CHAR_OP, 32'hffffffff);
               write_reg(REG_FG_OP, 32'd1);
               write_reg(REG_BG_OP, 32'd2);
               write_reg(REG_WR_CHAR, 32'd1);
               write_reg(REG_WR_FG, 32'd1);
               write_reg(REG_WR_BG, 32'd1);
               write_reg(REG_SPARE_B, 32'd0);
            end
            3: begin
               write_reg(REG_CHAR_OP, 32'd0);
               write_reg(REG_FG_OP, 32'd2);
               write_reg(REG_BG_OP, 32'd1);
            end
            default: begin
               write_reg(REG_CHAR_OP, $urandom());
               write_reg(REG_FG_OP, $urandom());
               write_reg(REG_BG_OP, $urandom());
               write_reg(REG_WR_CHAR, $urandom());
               write_reg(REG_WR_FG, $urandom());
               write_reg(REG_WR_BG, $urandom());
            end
         endcase
         csr_valid <= 1'b0;
         left = 70;
         while (left > 0) begin
            for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--) begin
               random_item();
               left--;
            end
            if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 25));
            if ($urandom_range(0, 19) == 0) drain();
         end
      end

      hold_off(1);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/tcb_pkg.sv
hdl/tcb_blend.sv
hdl/text_cell_blitter_with_blend_top.sv
tb/blit_checker.sv
tb/testbench.sv
